@@ hw/rtl/box_blur_3x3_defines.svh @@
// Assertion macros for the 3x3 box blur checker.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef BOX_BLUR_3X3_DEFINES_SVH
`define BOX_BLUR_3X3_DEFINES_SVH

// Same-cycle implication.
`define BB3_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BB3_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bb3_pkg.sv @@
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// No dependencies; bb3_avg, box_blur_3x3 and bb3_checker import it.
`timescale 1ns / 1ps

package bb3_pkg;

    localparam int CHAN_W      = 8;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 16;
    localparam int ROW_W       = HEIGHT_REG_W + 1;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int SUM_W       = 12;
    localparam int NUM_W       = SUM_W + 1;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic              func;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } blur_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              frame_last;
    } blur_res_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t top;
        rgb_t mid;
        rgb_t bot;
    } col_t;

    typedef struct packed {
        col_t left;
        col_t center;
        col_t right;
    } win_t;

    // One line store entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        rgb_t upper;
        rgb_t lower;
    } line_word_t;

    localparam int LINE_W = $bits(line_word_t);

    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } edge_mask_t;

    typedef struct packed {
        logic       sum_en;
        logic       mul_en;
        edge_mask_t mask;
    } avg_ctl_t;

    // ceil(2^17 / n): multiplying (2*sum + n) by it and shifting right by
    // RECIP_SHIFT gives the exact quotient for every sum that can occur.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        begin
            case (n)
                4'd1:    r = 18'd131072;
                4'd2:    r = 18'd65536;
                4'd3:    r = 18'd43691;
                4'd4:    r = 18'd32768;
                4'd6:    r = 18'd21846;
                4'd9:    r = 18'd14564;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/bb3_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bb3_avg.sv @@
// Neighborhood sum and rounded average of the 3x3 window, two register stages.
// Depends on bb3_pkg.
`timescale 1ns / 1ps

module bb3_avg (
    input  logic             clk,
    input  bb3_pkg::avg_ctl_t ctl,
    input  bb3_pkg::win_t    win,
    output bb3_pkg::rgb_t    avg
);

    import bb3_pkg::*;

    rgb_t              px [3][3];
    logic [2:0]        row_on;
    logic [2:0]        col_on;
    logic [1:0]        rows_n;
    logic [1:0]        cols_n;
    logic [CNT_W-1:0]  cnt;
    logic [SUM_W-1:0]  sum_r;
    logic [SUM_W-1:0]  sum_g;
    logic [SUM_W-1:0]  sum_b;
    logic [NUM_W-1:0]  num_r_reg;
    logic [NUM_W-1:0]  num_g_reg;
    logic [NUM_W-1:0]  num_b_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic [PROD_W-1:0] prod_r_reg;
    logic [PROD_W-1:0] prod_g_reg;
    logic [PROD_W-1:0] prod_b_reg;

    assign row_on = {ctl.mask.bot, 1'b1, ctl.mask.top};
    assign col_on = {ctl.mask.right, 1'b1, ctl.mask.left};
    assign rows_n = 2'd1 + {1'b0, ctl.mask.top} + {1'b0, ctl.mask.bot};
    assign cols_n = 2'd1 + {1'b0, ctl.mask.left} + {1'b0, ctl.mask.right};
    assign cnt    = {2'b00, rows_n} * {2'b00, cols_n};

    always_comb
    begin
        px[0][0] = win.left.top;
        px[0][1] = win.left.mid;
        px[0][2] = win.left.bot;
        px[1][0] = win.center.top;
        px[1][1] = win.center.mid;
        px[1][2] = win.center.bot;
        px[2][0] = win.right.top;
        px[2][1] = win.right.mid;
        px[2][2] = win.right.bot;
    end

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (col_on[c] && row_on[r])
                begin
                    sum_r = sum_r + SUM_W'(px[c][r].red);
                    sum_g = sum_g + SUM_W'(px[c][r].green);
                    sum_b = sum_b + SUM_W'(px[c][r].blue);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            num_r_reg <= {sum_r, 1'b0} + NUM_W'(cnt);
            num_g_reg <= {sum_g, 1'b0} + NUM_W'(cnt);
            num_b_reg <= {sum_b, 1'b0} + NUM_W'(cnt);
            recip_reg <= recip_of(cnt);
        end
        if (ctl.mul_en)
        begin
            prod_r_reg <= PROD_W'(num_r_reg) * PROD_W'(recip_reg);
            prod_g_reg <= PROD_W'(num_g_reg) * PROD_W'(recip_reg);
            prod_b_reg <= PROD_W'(num_b_reg) * PROD_W'(recip_reg);
        end
    end

    assign avg.red   = prod_r_reg[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
    assign avg.green = prod_g_reg[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
    assign avg.blue  = prod_b_reg[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];

endmodule

@@ hw/rtl/box_blur_3x3.sv @@
// Top level of the 3x3 box blur: configuration registers, sequencer, counters,
// window registers and output register. Depends on bb3_pkg, bb3_ram, bb3_avg.
`timescale 1ns / 1ps

// Pixels enter on the pixel channel in raster order, one request per pixel;
// a request with func set is a drain tick. Results leave on the blur channel.
// The result for a pixel is produced by the request that arrives one row plus
// one pixel later; once the whole frame is in, each drain tick yields one of
// the remaining results, and the last carries frame_last.
// A pixel that is stored without producing a result passes through the load
// state and back to idle; a request that is ignored (an early drain tick or
// a pixel past the frame) leaves the block idle; one that produces a result
// passes through the load, sum, multiply and output states. The first drain
// tick of a one-row frame passes through an extra step and load state. These
// steps come from the read-modify-write of the line store (one read port,
// registered read), then the sum stage and the reciprocal multiply stage.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the sequencer holds its next result until
// the register frees. Reset clears the counters and sets width and height to
// one; the line store is not cleared. Writing either register restarts the
// frame.
module box_blur_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  bb3_pkg::blur_req_t                pixel,
    output logic                              blur_valid,
    input  logic                              blur_ready,
    output bb3_pkg::blur_res_t                blur,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bb3_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bb3_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bb3_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    import bb3_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LIM_W = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
                           $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_STEP = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [COL_W-1:0]        vcol_reg;
    logic [COL_W-1:0]        vcol_next;
    logic [ROW_W-1:0]        vrow_reg;
    logic [ROW_W-1:0]        vrow_next;
    logic [COL_W-1:0]        ecol_reg;
    logic [COL_W-1:0]        ecol_next;
    logic [HEIGHT_REG_W-1:0] erow_reg;
    logic [HEIGHT_REG_W-1:0] erow_next;
    logic                    real_reg;
    logic                    emit_reg;
    logic                    blur_valid_reg;
    logic                    blur_valid_next;
    rgb_t                    pix_reg;
    logic [COL_W-1:0]        col_reg;
    logic                    last_reg;
    win_t                    win_reg;
    blur_res_t               blur_reg;

    logic                    cfg_write;
    logic                    reg_sel;
    logic [LIM_W-1:0]        width_ext;
    logic [LIM_W-1:0]        wlast_full;
    logic [COL_W-1:0]        w_last;
    logic [HEIGHT_REG_W-1:0] h_last;
    logic                    data_ok;
    logic                    primed;
    logic                    step_go;
    logic                    is_last;
    logic                    out_load;
    logic [LINE_W-1:0]       ram_rdata;
    line_word_t              rd_word;
    line_word_t              wr_word;
    col_t                    new_col;
    avg_ctl_t                avg_ctl;
    rgb_t                    avg;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective last column and last row.
    assign width_ext = LIM_W'(width_reg);

    always_comb
    begin
        if (width_reg == '0)
        begin
            wlast_full = '0;
        end
        else if (width_ext > LIM_W'(MAX_WIDTH))
        begin
            wlast_full = LIM_W'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast_full = width_ext - LIM_W'(1);
        end
    end

    assign w_last = wlast_full[COL_W-1:0];
    assign h_last = (height_reg == '0) ? '0 : height_reg - HEIGHT_REG_W'(1);

    // Stepping through the (possibly virtual) pixel positions.
    assign data_ok     = vrow_reg <= {1'b0, h_last};
    assign primed      = (|vrow_reg[ROW_W-1:1]) | (vrow_reg[0] & (|vcol_reg));
    assign pixel_ready = (state_reg == ST_IDLE);
    assign step_go     = ((state_reg == ST_IDLE) && pixel_valid &&
                          (((pixel.func == FUNC_PIXEL) && data_ok) ||
                           ((pixel.func == FUNC_DRAIN) && !data_ok))) ||
                         (state_reg == ST_STEP);
    assign is_last     = (erow_reg == h_last) && (ecol_reg == w_last);
    assign out_load    = (state_reg == ST_OUT) && (!blur_valid_reg || blur_ready);

    // Line store: read at request time, written back in the next cycle. The
    // sequencer never issues the next read before that write, so the same
    // column cannot be read stale.
    assign rd_word       = ram_rdata;
    assign wr_word.upper = rd_word.lower;
    assign wr_word.lower = pix_reg;
    assign new_col.top   = rd_word.upper;
    assign new_col.mid   = rd_word.lower;
    assign new_col.bot   = pix_reg;

    bb3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    ((state_reg == ST_LOAD) && real_reg),
        .waddr (col_reg),
        .wdata (wr_word),
        .re    (step_go),
        .raddr (vcol_reg),
        .rdata (ram_rdata)
    );

    assign avg_ctl.sum_en     = (state_reg == ST_SUM);
    assign avg_ctl.mul_en     = (state_reg == ST_MUL);
    assign avg_ctl.mask.top   = (erow_reg != '0);
    assign avg_ctl.mask.bot   = (erow_reg != h_last);
    assign avg_ctl.mask.left  = (ecol_reg != '0);
    assign avg_ctl.mask.right = (ecol_reg != w_last);

    bb3_avg u_avg (
        .clk (clk),
        .ctl (avg_ctl),
        .win (win_reg),
        .avg (avg)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (step_go)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (emit_reg)
                begin
                    state_next = ST_SUM;
                end
                else if (!real_reg)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP: state_next = ST_LOAD;
            ST_SUM:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        vcol_next = vcol_reg;
        vrow_next = vrow_reg;
        ecol_next = ecol_reg;
        erow_next = erow_reg;
        if (step_go)
        begin
            if (vcol_reg == w_last)
            begin
                vcol_next = '0;
                vrow_next = vrow_reg + ROW_W'(1);
            end
            else
            begin
                vcol_next = vcol_reg + COL_W'(1);
            end
        end
        if (state_reg == ST_SUM)
        begin
            if (is_last)
            begin
                vcol_next = '0;
                vrow_next = '0;
                ecol_next = '0;
                erow_next = '0;
            end
            else if (ecol_reg == w_last)
            begin
                ecol_next = '0;
                erow_next = erow_reg + HEIGHT_REG_W'(1);
            end
            else
            begin
                ecol_next = ecol_reg + COL_W'(1);
            end
        end
        if (cfg_write)
        begin
            vcol_next = '0;
            vrow_next = '0;
            ecol_next = '0;
            erow_next = '0;
        end
    end

    always_comb
    begin
        blur_valid_next = blur_valid_reg;
        if (out_load)
        begin
            blur_valid_next = 1'b1;
        end
        else if (blur_ready)
        begin
            blur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_reg      <= WIDTH_REG_W'(1);
            height_reg     <= HEIGHT_REG_W'(1);
            vcol_reg       <= '0;
            vrow_reg       <= '0;
            ecol_reg       <= '0;
            erow_reg       <= '0;
            real_reg       <= 1'b0;
            emit_reg       <= 1'b0;
            blur_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vcol_reg       <= vcol_next;
            vrow_reg       <= vrow_next;
            ecol_reg       <= ecol_next;
            erow_reg       <= erow_next;
            blur_valid_reg <= blur_valid_next;
            if (step_go)
            begin
                real_reg <= (state_reg == ST_IDLE) && (pixel.func == FUNC_PIXEL);
                emit_reg <= primed;
            end
            if (cfg_write)
            begin
                case (reg_sel)
                    REG_FRAME_WIDTH:  width_reg  <= pwdata[WIDTH_REG_W-1:0];
                    REG_FRAME_HEIGHT: height_reg <= pwdata[HEIGHT_REG_W-1:0];
                    default:          width_reg  <= width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            col_reg       <= vcol_reg;
            pix_reg.red   <= pixel.in_red;
            pix_reg.green <= pixel.in_green;
            pix_reg.blue  <= pixel.in_blue;
        end
        if (state_reg == ST_LOAD)
        begin
            win_reg.left   <= win_reg.center;
            win_reg.center <= win_reg.right;
            win_reg.right  <= new_col;
        end
        if (state_reg == ST_SUM)
        begin
            last_reg <= is_last;
        end
        if (out_load)
        begin
            blur_reg.out_red    <= avg.red;
            blur_reg.out_green  <= avg.green;
            blur_reg.out_blue   <= avg.blue;
            blur_reg.frame_last <= last_reg;
        end
    end

    assign blur_valid = blur_valid_reg;
    assign blur       = blur_reg;

endmodule

@@ hw/rtl/bb3_checker.sv @@
// Port-level checker for the 3x3 box blur, bound to the top level.
// Depends on bb3_pkg and box_blur_3x3_defines.svh.
`timescale 1ns / 1ps
`include "box_blur_3x3_defines.svh"

module bb3_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pixel_valid,
    input logic               pixel_ready,
    input logic               blur_valid,
    input logic               blur_ready,
    input bb3_pkg::blur_res_t blur
);

    import bb3_pkg::*;

    // A stalled result keeps its value.
    `BB3_ASSERT_NEXT(a_blur_hold, blur_valid && !blur_ready, blur_valid && $stable(blur), "stalled result changed")

    // The block only becomes busy by taking a request.
    `BB3_ASSERT_IMPL(a_busy_after_req, $fell(pixel_ready), $past(pixel_valid), "ready fell without a request")

    // A new result cannot rise until the request taken before it has passed through the load, sum and multiply states.
    `BB3_ASSERT_IMPL(a_min_latency, $rose(blur_valid), !$past(pixel_valid && pixel_ready, 1) && !$past(pixel_valid && pixel_ready, 2) && !$past(pixel_valid && pixel_ready, 3), "result too early")

endmodule

bind box_blur_3x3 bb3_checker u_bb3_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .blur_valid  (blur_valid),
    .blur_ready  (blur_ready),
    .blur        (blur)
);
